/* hdl/icy_dfr_pkg.sv */
package icy_dfr_pkg;

  localparam int ByteW     = 8;
  localparam int IntervalW = 24;
  localparam int RemainW   = 12;
  localparam int PhaseW    = 2;

  // Metadata block length is counted in units of 16 bytes.
  localparam int BlockUnitShift = 4;

  localparam logic [PhaseW-1:0] PH_AUDIO  = 2'd0;
  localparam logic [PhaseW-1:0] PH_LENGTH = 2'd1;
  localparam logic [PhaseW-1:0] PH_META   = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] payload_byte;
    logic             is_metadata;
    logic             block_last;
  } result_t;

endpackage

/* hdl/icy_dfr_framer.sv */
module icy_dfr_framer
  import icy_dfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IntervalW-1:0] cfg_wdata,
  input  logic                 step,
  input  logic [ByteW-1:0]     step_byte,
  output result_t              result
);

  logic [IntervalW-1:0] meta_interval;
  logic [PhaseW-1:0]    phase, phase_next;
  logic [IntervalW-1:0] audio_count, audio_count_next;
  logic [RemainW-1:0]   metadata_remaining, metadata_remaining_next;
  logic [RemainW-1:0]   block_len;
  logic                 meta_last;

  assign block_len = {step_byte, {BlockUnitShift{1'b0}}};
  assign meta_last = metadata_remaining inside {RemainW'(0), RemainW'(1)};

  always_comb begin
    phase_next              = phase;
    audio_count_next        = audio_count;
    metadata_remaining_next = metadata_remaining;
    result.valid            = 1'b1;
    result.payload_byte     = step_byte;
    result.is_metadata      = 1'b0;
    result.block_last       = 1'b0;
    if (meta_interval != '0) begin
      case (phase)
        PH_LENGTH: begin
          result.valid = 1'b0;
          if (block_len == '0) begin
            phase_next       = PH_AUDIO;
            audio_count_next = meta_interval;
          end else begin
            phase_next              = PH_META;
            metadata_remaining_next = block_len;
          end
        end
        PH_META: begin
          result.is_metadata = 1'b1;
          result.block_last  = meta_last;
          if (meta_last) begin
            phase_next              = PH_AUDIO;
            audio_count_next        = meta_interval;
            metadata_remaining_next = '0;
          end else begin
            metadata_remaining_next = metadata_remaining - RemainW'(1);
          end
        end
        default: begin
          // The unused phase code behaves as the audio phase.
          if (audio_count inside {IntervalW'(0), IntervalW'(1)}) begin
            audio_count_next = '0;
            phase_next       = PH_LENGTH;
          end else begin
            audio_count_next = audio_count - IntervalW'(1);
            phase_next       = PH_AUDIO;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval      <= '0;
      phase              <= PH_AUDIO;
      audio_count        <= '0;
      metadata_remaining <= '0;
    end else if (cfg_we) begin
      // A new interval restarts the framing at the head of an audio run.
      meta_interval      <= cfg_wdata;
      phase              <= PH_AUDIO;
      audio_count        <= cfg_wdata;
      metadata_remaining <= '0;
    end else if (step) begin
      phase              <= phase_next;
      audio_count        <= audio_count_next;
      metadata_remaining <= metadata_remaining_next;
    end
  end

endmodule

/* hdl/icy_metadata_deframer_core.sv */
// Splits a received ICY byte stream into audio and metadata items. Every input
// item is one stream byte; after cfg_wdata audio bytes comes a length byte,
// which is swallowed, and then sixteen times that many metadata bytes, marked
// by tuser and closed by tlast. A zero interval passes all bytes through as
// audio, and writing the interval restarts the framing at an audio run. One
// item is taken every clock cycle while the output is being drained. A byte is
// held in the input register until the result register is free; there the
// framing counters are stepped and, for all but length bytes, the result
// register is loaded. A stalled output holds the input register, which then
// stalls the input.
module icy_metadata_deframer_core
  import icy_dfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IntervalW-1:0] cfg_wdata,     // meta_interval
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,  // stream_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ByteW-1:0]     m_axis_tdata,  // payload_byte
  output logic                 m_axis_tuser,  // is_metadata
  output logic                 m_axis_tlast   // block_last
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             out_free;
  logic             advance;
  result_t          res;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  icy_dfr_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .step_byte (in_byte),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_axis_tdata <= res.payload_byte;
      m_axis_tuser <= res.is_metadata;
      m_axis_tlast <= res.block_last;
    end
  end

  a_last_is_meta: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("block_last set on an audio item");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |-> !s_axis_tready)
    else $error("input accepted while the held byte cannot move on");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid |=> m_axis_tvalid)
    else $error("result item lost on its way to the result register");

  a_length_silent: assert property (@(posedge clk) disable iff (rst)
    advance && !res.valid && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result item invented for a length byte");

endmodule

/* test/icy_metadata_deframer_core_test.sv */
`timescale 1ns / 1ps

module icy_metadata_deframer_core_test;
  import icy_dfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES = 400;
  localparam int CUT_BLOCK_BYTES = 64;
  localparam logic [IntervalW-1:0] INTERVAL_MAX = '1;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             meta;
    logic             last;
  } out_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [IntervalW-1:0] cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ByteW-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  icy_metadata_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Framing state as the block should hold it.
  logic [IntervalW-1:0] dfr_interval = '0;
  logic [PhaseW-1:0]    dfr_phase = PH_AUDIO;
  logic [IntervalW-1:0] audio_left = '0;
  logic [RemainW-1:0]   meta_left = '0;

  logic [ByteW-1:0] stream_bytes[$];
  out_item_t        expected_out[$];

  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int holds_done = 0;

  task automatic rearm_framing();
    dfr_phase = PH_AUDIO;
    audio_left = dfr_interval;
    meta_left = '0;
  endtask

  task automatic emit(input logic [ByteW-1:0] b, input logic meta, input logic last);
    out_item_t r;
    r.data = b;
    r.meta = meta;
    r.last = last;
    expected_out.push_back(r);
  endtask

  // Steps the framing on one accepted stream byte and records the item it yields.
  task automatic step_deframer(input logic [ByteW-1:0] b);
    logic [RemainW-1:0] block_len;
    logic               last;
    block_len = {b, {BlockUnitShift{1'b0}}};
    if (dfr_interval == '0) begin
      emit(b, 1'b0, 1'b0);
    end else begin
      case (dfr_phase)
        PH_LENGTH: begin
          if (block_len == '0) begin
            rearm_framing();
          end else begin
            dfr_phase = PH_META;
            meta_left = block_len;
          end
        end
        PH_META: begin
          last = (meta_left <= 1);
          emit(b, 1'b1, last);
          if (last) begin
            rearm_framing();
          end else begin
            meta_left = meta_left - 1'b1;
          end
        end
        default: begin
          emit(b, 1'b0, 1'b0);
          if (audio_left <= 1) begin
            audio_left = '0;
            dfr_phase = PH_LENGTH;
          end else begin
            audio_left = audio_left - 1'b1;
            dfr_phase = PH_AUDIO;
          end
        end
      endcase
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_deframer(s_axis_tdata);
        void'(stream_bytes.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (stream_bytes.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= stream_bytes[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Long hold-offs on the output while the sender keeps offering, so the block
  // fills up and has to stall its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!rst && s_axis_tvalid &&
                 ((holds_done == 0 && cycle_count >= 300) ||
                  (holds_done == 1 && cycle_count >= 1500))) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: a stall pattern that changes character every so often.
  int stall_mode = 0;
  int stall_span = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (stall_span % 4) != 0;
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: data %h meta %b last %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tuser !== want.meta ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected data %h meta %b last %b, got data %h meta %b last %b",
                     want.data, want.meta, want.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  task automatic wait_idle();
    while (stream_bytes.size() != 0 || expected_out.size() != 0)
      @(posedge clk);
    // A trailing length byte yields nothing, so give the pipeline time to drain.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [IntervalW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dfr_interval = v;
    rearm_framing();
  endtask

  // Queues well-formed rounds with random content, cut off after n items.
  task automatic push_rounds(input logic [IntervalW-1:0] iv, input int n);
    int made;
    int k;
    int len;
    made = 0;
    while (made < n) begin
      if (iv == '0) begin
        stream_bytes.push_back(ByteW'($urandom_range(0, 255)));
        made++;
      end else begin
        for (k = 0; k < iv && made < n; k++) begin
          stream_bytes.push_back(ByteW'($urandom_range(0, 255)));
          made++;
        end
        if (made < n) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
          stream_bytes.push_back(ByteW'(len));
          made++;
          for (k = 0; k < len * 16 && made < n; k++) begin
            stream_bytes.push_back(ByteW'($urandom_range(0, 255)));
            made++;
          end
        end
      end
    end
  endtask

  initial begin
    int i;
    int random_items;
    int n;
    logic [IntervalW-1:0] iv;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the interval is zero, so everything passes as audio.
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'hA5);
    stream_bytes.push_back(8'h5A);
    wait_idle();

    // Shortest rounds: an empty block, then a one-unit block of sixteen bytes.
    write_interval(IntervalW'(1));
    stream_bytes.push_back(8'h3C);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hC3);
    stream_bytes.push_back(8'h01);
    for (i = 0; i < 16; i++)
      stream_bytes.push_back(i == 0 ? 8'hFF :
                             (i == 15 ? 8'h00 : ByteW'($urandom_range(0, 255))));
    wait_idle();

    // The largest length byte, cut off part way through its block; the next
    // interval write re-arms the framing.
    write_interval(IntervalW'(3));
    for (i = 0; i < 3; i++)
      stream_bytes.push_back(ByteW'($urandom_range(0, 255)));
    stream_bytes.push_back(8'hFF);
    for (i = 0; i < CUT_BLOCK_BYTES; i++)
      stream_bytes.push_back(ByteW'($urandom_range(0, 255)));
    wait_idle();
    write_interval(IntervalW'(3));
    push_rounds(IntervalW'(3), 60);
    wait_idle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: iv = '0;
        1: iv = IntervalW'(1);
        2: iv = IntervalW'(2);
        3: iv = INTERVAL_MAX;
        4: iv = IntervalW'($urandom_range(3, 20));
        5: iv = IntervalW'($urandom_range(1, 64));
        6: iv = IntervalW'($urandom);
        default: iv = IntervalW'($urandom_range(5, 12));
      endcase
      n = $urandom_range(20, 160);
      write_interval(iv);
      push_rounds(iv, n);
      random_items += n;
      wait_idle();
    end

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/icy_dfr_pkg.sv
hdl/icy_dfr_framer.sv
hdl/icy_metadata_deframer_core.sv
test/icy_metadata_deframer_core_test.sv
